// File: sv/aspd_pkg.sv
`default_nettype none

package aspd_pkg;

  // Input event codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Bus request codes
  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Event status codes
  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_BUS_ERR  = 3'd2;
  localparam logic [2:0] ST_RESERVED = 3'd3;
  localparam logic [2:0] ST_STALE    = 3'd4;
  localparam logic [2:0] ST_FAULT    = 3'd5;

  // Status bits carried in the top of the sensor frame
  localparam logic [1:0] FRAME_GOOD     = 2'd0;
  localparam logic [1:0] FRAME_RESERVED = 2'd1;
  localparam logic [1:0] FRAME_STALE    = 2'd2;
  localparam logic [1:0] FRAME_FAULT    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_KIND  = 2'd0;
  localparam logic [1:0] CFG_WAIT  = 2'd1;
  localparam logic [1:0] CFG_STALE = 2'd2;

  localparam int CFG_DATA_W = 16;

  // Reset values of the configuration
  localparam logic [7:0]  WAIT_RESET  = 8'd10;
  localparam logic [15:0] STALE_RESET = 16'd100;

  // Pressure decode: P = sign * floor((mag * gain + half) / div), where the psi
  // formula also adds 8 * mag (its gain is 8 * div + PSI_GAIN).
  localparam logic signed [16:0] PSI_ZERO  = 17'sd16383;
  localparam logic signed [16:0] INW_ZERO  = 17'sd1638;
  localparam logic [18:0] PSI_GAIN  = 19'd341557;
  localparam logic [18:0] INW_GAIN  = 19'd199072;
  localparam logic [33:0] PSI_HALF  = 34'd409575;
  localparam logic [33:0] INW_HALF  = 34'd163837;
  localparam logic [14:0] PSI_RECIP = 15'd10486;   // floor(2^33 / 819150)
  localparam logic [14:0] INW_RECIP = 15'd26214;   // floor(2^33 / 327675)
  localparam logic [33:0] PSI_DIV   = 34'd819150;
  localparam logic [33:0] INW_DIV   = 34'd327675;

  // Temperature decode: T = sign * floor((|3200*dt - 1637600| + 1023) / 2047)
  localparam logic [23:0] TMP_SCALE  = 24'd3200;
  localparam logic [23:0] TMP_OFFSET = 24'd1637600;
  localparam logic [22:0] TMP_HALF   = 23'd1023;
  localparam logic [35:0] TMP_RECIP  = 36'd4098;  // floor(2^23 / 2047)
  localparam logic [22:0] TMP_DIV    = 23'd2047;

  // Result beat, lowest field in the lowest bits
  typedef struct packed {
    logic                fresh;
    logic signed [12:0]  temperature;
    logic signed [18:0]  pressure;
    logic [2:0]          status;
    logic [1:0]          req;
  } result_t;

  // Second stage: control outcome and first product
  typedef struct packed {
    logic [1:0]  req;
    logic [2:0]  status;
    logic        fresh;
    logic        dec;
    logic        kind;
    logic        neg_p;
    logic [17:0] base;
    logic [33:0] prod;
    logic        neg_t;
    logic [22:0] nt;
  } s2_t;

  // Third stage: quotient estimates before correction
  typedef struct packed {
    logic [1:0]  req;
    logic [2:0]  status;
    logic        fresh;
    logic        dec;
    logic        kind;
    logic        neg_p;
    logic [17:0] base;
    logic [33:0] n;
    logic [13:0] qe;
    logic        neg_t;
    logic [22:0] nt;
    logic [11:0] qet;
  } s3_t;

endpackage

`default_nettype wire

// File: sv/airspeed_sensor_poll_and_decode_top.sv
`default_nettype none

// Poller and decoder for a 4-byte differential-pressure sensor on a host bus.
//
// Input stream (s_*): one beat per event. s_tuser carries the event kind
// (millisecond tick, measure write finished, frame read finished); s_tdata
// carries the bus outcome flag and the four received frame bytes.
// Output stream (m_*): exactly one beat per input beat, in order, carrying the
// bus request to issue next, an event status, the stored pressure (1/16 Pa)
// and temperature (1/16 degC), and the freshness flag.
// Configuration: write cfg_data to register cfg_index while cfg_we is high,
// only while no beat is in flight. Index 0 selects the sensor formula, 1 the
// conversion wait in ms, 2 the staleness limit in ms.
//
// Throughput: one beat per cycle while the receiver is not stalling. A beat
// passes from input acceptance to m_tvalid through the input register, then the
// product and reciprocal-estimate stages of the divide-by-constant decode, then
// remainder correction into the output register.
// When the receiver stalls, the whole pipeline holds and s_tready drops until
// the output beat is taken. Reset clears the pipeline, the schedule, the stored
// sample and returns the configuration to its defaults; no clearing pass.
module airspeed_sensor_poll_and_decode_top
  import aspd_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [39:0]           s_tdata,   // [0] bus_ok, [32:1] frame_bytes, rest zero
  input  wire logic [1:0]            s_tuser,   // [1:0] opcode
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [39:0]                m_tdata,   // [1:0] bus_request, [4:2] event_status,
                                                // [23:5] pressure_sixteenth_pa,
                                                // [36:24] temperature_sixteenth_c,
                                                // [37] sample_fresh, rest zero
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic        kind;
  logic [7:0]  conv_wait;
  logic [15:0] stale_limit;

  // Schedule and sample state
  logic [TIME_BITS-1:0] now_ms;
  logic                 measure_pending;
  logic [TIME_BITS-1:0] measure_start_ms;
  logic                 have_sample;
  logic [TIME_BITS-1:0] last_sample_ms;
  logic signed [18:0]   pressure_store;
  logic signed [12:0]   temperature_store;

  // Pipeline
  logic        adv;
  logic        v1, v2, v3;
  logic [1:0]  op1;
  logic        ok1;
  logic [31:0] frame1;
  s2_t         s2, s2_next;
  s3_t         s3, s3_next;
  result_t     out_q;

  // Advance every stage together whenever the output register can take a beat
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tdata  = {2'b00, out_q};

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      kind        <= 1'b0;
      conv_wait   <= WAIT_RESET;
      stale_limit <= STALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KIND:  kind        <= cfg_data[0];
        CFG_WAIT:  conv_wait   <= cfg_data[7:0];
        CFG_STALE: stale_limit <= cfg_data[15:0];
        default:   ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 0
  // Register the input beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1    <= s_tuser;
      ok1    <= s_tdata[0];
      frame1 <= s_tdata[32:1];
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Schedule decisions, state update and the first decode products.
  logic [TIME_BITS-1:0] now_next;
  logic                 pending_next;
  logic [TIME_BITS-1:0] start_next;
  logic                 have_next;
  logic [TIME_BITS-1:0] last_next;
  logic [1:0]           req1;
  logic [2:0]           status1;
  logic                 dec1;
  logic [TIME_BITS-1:0] wait_age;
  logic [TIME_BITS-1:0] sample_age;
  logic [13:0]          dp;
  logic [10:0]          dt;
  logic signed [16:0]   xp;
  logic signed [16:0]   xi;
  logic signed [16:0]   xsel;
  logic [16:0]          xmag;
  logic [14:0]          pmag;
  logic [23:0]          tscaled;
  logic                 tneg;
  logic [23:0]          tmag;

  always_comb begin
    now_next     = now_ms;
    pending_next = measure_pending;
    start_next   = measure_start_ms;
    have_next    = have_sample;
    last_next    = last_sample_ms;
    req1         = REQ_NONE;
    status1      = ST_NONE;
    dec1         = 1'b0;
    wait_age     = '0;
    unique case (op1)
      OP_TICK: begin
        now_next = now_ms + TIME_BITS'(1);
        wait_age = now_next - measure_start_ms;
        if (!measure_pending) begin
          req1 = REQ_START;
        end else if (wait_age > TIME_BITS'(conv_wait)) begin
          req1 = REQ_READ;
        end
      end
      OP_WRITE: begin
        if (ok1) begin
          pending_next = 1'b1;
          start_next   = now_ms;
        end else begin
          pending_next = 1'b0;
          status1      = ST_BUS_ERR;
        end
      end
      OP_READ: begin
        pending_next = 1'b0;
        req1         = REQ_START;
        if (!ok1) begin
          status1 = ST_BUS_ERR;
        end else begin
          case (frame1[31:30])
            FRAME_GOOD: begin
              dec1      = 1'b1;
              have_next = 1'b1;
              last_next = now_ms;
              status1   = ST_OK;
            end
            FRAME_RESERVED: status1 = ST_RESERVED;
            FRAME_STALE:    status1 = ST_STALE;
            default:        status1 = ST_FAULT;
          endcase
        end
      end
      default: ;
    endcase
    sample_age = now_next - last_next;
  end

  // Signed offset of the pressure count from the formula's zero point
  assign dp      = frame1[29:16];
  assign dt      = frame1[15:5];
  assign xp      = PSI_ZERO - $signed({2'b00, dp, 1'b0});
  assign xi      = INW_ZERO - $signed({3'b000, dp});
  assign xsel    = kind ? xi : xp;
  assign xmag    = xsel[16] ? 17'(-xsel) : 17'(xsel);
  assign pmag    = xmag[14:0];
  assign tscaled = 24'(dt) * TMP_SCALE;
  assign tneg    = tscaled < TMP_OFFSET;
  assign tmag    = tneg ? (TMP_OFFSET - tscaled) : (tscaled - TMP_OFFSET);

  always_comb begin
    s2_next        = '0;
    s2_next.req    = req1;
    s2_next.status = status1;
    s2_next.fresh  = have_next && (sample_age <= TIME_BITS'(stale_limit));
    s2_next.dec    = dec1;
    s2_next.kind   = kind;
    s2_next.neg_p  = xsel[16];
    s2_next.base   = kind ? 18'd0 : {pmag, 3'b000};
    s2_next.prod   = 34'(pmag) * 34'(kind ? INW_GAIN : PSI_GAIN);
    s2_next.neg_t  = tneg;
    s2_next.nt     = tmag[22:0] + TMP_HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms           <= '0;
      measure_pending  <= 1'b0;
      measure_start_ms <= '0;
      have_sample      <= 1'b0;
      last_sample_ms   <= '0;
      v2               <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
      if (v1) begin
        now_ms           <= now_next;
        measure_pending  <= pending_next;
        measure_start_ms <= start_next;
        have_sample      <= have_next;
        last_sample_ms   <= last_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2 <= s2_next;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Quotient estimates by reciprocal multiply; each is low by at most one.
  logic [33:0] pn;
  logic [48:0] pq_full;
  logic [35:0] tq_full;

  assign pn      = s2.prod + (s2.kind ? INW_HALF : PSI_HALF);
  assign pq_full = 49'(pn) * 49'(s2.kind ? INW_RECIP : PSI_RECIP);
  assign tq_full = 36'(s2.nt) * TMP_RECIP;

  always_comb begin
    s3_next        = '0;
    s3_next.req    = s2.req;
    s3_next.status = s2.status;
    s3_next.fresh  = s2.fresh;
    s3_next.dec    = s2.dec;
    s3_next.kind   = s2.kind;
    s3_next.neg_p  = s2.neg_p;
    s3_next.base   = s2.base;
    s3_next.n      = pn;
    s3_next.qe     = pq_full[46:33];
    s3_next.neg_t  = s2.neg_t;
    s3_next.nt     = s2.nt;
    s3_next.qet    = tq_full[34:23];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3 <= s3_next;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Correct the estimates with one remainder compare, apply the sign.
  logic [33:0]        pdiv;
  logic [33:0]        prem;
  logic [14:0]        pq;
  logic [17:0]        pabs;
  logic signed [18:0] pressure_new;
  logic [22:0]        trem;
  logic [11:0]        tq;
  logic signed [12:0] temperature_new;
  logic signed [18:0] pressure_out;
  logic signed [12:0] temperature_out;

  assign pdiv = s3.kind ? INW_DIV : PSI_DIV;
  assign prem = s3.n - 34'(s3.qe) * pdiv;
  assign pq   = 15'(s3.qe) + 15'(prem >= pdiv);
  assign pabs = s3.base + 18'(pq);
  assign pressure_new = s3.neg_p ? -$signed({1'b0, pabs}) : $signed({1'b0, pabs});

  assign trem = s3.nt - 23'(s3.qet) * TMP_DIV;
  assign tq   = s3.qet + 12'(trem >= TMP_DIV);
  assign temperature_new = s3.neg_t ? -$signed({1'b0, tq}) : $signed({1'b0, tq});

  assign pressure_out    = s3.dec ? pressure_new : pressure_store;
  assign temperature_out = s3.dec ? temperature_new : temperature_store;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid          <= 1'b0;
      pressure_store    <= '0;
      temperature_store <= '0;
    end else if (adv) begin
      m_tvalid <= v3;
      if (v3 && s3.dec) begin
        pressure_store    <= pressure_new;
        temperature_store <= temperature_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v3) begin
      out_q.req         <= s3.req;
      out_q.status      <= s3.status;
      out_q.pressure    <= pressure_out;
      out_q.temperature <= temperature_out;
      out_q.fresh       <= s3.fresh;
    end
  end

  // ---------------------------------------------------------------- checks
  // A decoded frame leaves the pipeline reported as a good sample.
  a_dec_reports_ok: assert property (@(posedge clk) disable iff (rst)
    (adv && v3 && s3.dec) |=> (m_tvalid && out_q.status == ST_OK))
    else $error("decoded frame not reported as good sample");

  // A read request in flight implies a measurement is pending.
  a_read_needs_pending: assert property (@(posedge clk) disable iff (rst)
    (v2 && s2.req == REQ_READ) |-> measure_pending)
    else $error("read requested without pending measurement");

  // A finished read always clears the pending measurement.
  a_read_clears: assert property (@(posedge clk) disable iff (rst)
    (adv && v1 && op1 == OP_READ) |=> !measure_pending)
    else $error("pending measurement survived a frame read");

  // Freshness is only claimed once a sample exists.
  a_fresh_has_sample: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_q.fresh) |-> have_sample)
    else $error("fresh flag without a stored sample");

  // Decoded temperature stays in the sensor's range.
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_q.temperature >= -13'sd800 && out_q.temperature <= 13'sd2400))
    else $error("temperature outside sensor range");

endmodule

`default_nettype wire

// File: bench/aspd_checker.sv
module aspd_checker
  import aspd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [39:0]           s_tdata,   // [0] bus_ok, [32:1] frame_bytes, rest zero
  input  logic [1:0]            s_tuser,   // [1:0] opcode
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [39:0]           m_tdata,   // [1:0] bus_request, [4:2] event_status,
                                           // [23:5] pressure, [36:24] temperature,
                                           // [37] sample_fresh, rest zero
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // Decode coefficients, all in 1/16 units
  localparam longint DEC_PSI_GAIN   = 6894757;
  localparam longint DEC_PSI_SPAN   = 16383;
  localparam longint DEC_PSI_DEN    = 819150;
  localparam longint DEC_INW_GAIN   = 199072;
  localparam longint DEC_INW_ZERO   = 1638;
  localparam longint DEC_INW_DEN    = 327675;
  localparam longint DEC_TMP_GAIN   = 3200;
  localparam longint DEC_TMP_OFFSET = 800 * 2047;
  localparam longint DEC_TMP_DEN    = 2047;

  // Mirror of the configuration registers
  logic        kind_q;
  logic [7:0]  wait_q;
  logic [15:0] stale_q;

  // Mirror of the poller state
  logic [31:0]        clock_ms;
  logic [31:0]        start_ms;
  logic [31:0]        sample_ms;
  logic               pending_q;
  logic               have_q;
  logic signed [18:0] press_q;
  logic signed [12:0] temp_q;

  result_t owed_q[$];

  // Round to nearest, ties away from zero
  function automatic longint round_div(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  task automatic step_poller(input logic [1:0] op, input logic ok, input logic [31:0] frame,
                             output result_t res);
    longint dp;
    longint dt;
    longint p;
    longint t;
    res = '0;
    case (op)
      OP_TICK: begin
        clock_ms = clock_ms + 32'd1;
        if (!pending_q)
          res.req = REQ_START;
        else if (32'(clock_ms - start_ms) > 32'(wait_q))
          res.req = REQ_READ;
      end
      OP_WRITE: begin
        if (ok) begin
          pending_q = 1'b1;
          start_ms = clock_ms;
        end else begin
          pending_q = 1'b0;
          res.status = ST_BUS_ERR;
        end
      end
      OP_READ: begin
        pending_q = 1'b0;
        res.req = REQ_START;
        if (!ok) begin
          res.status = ST_BUS_ERR;
        end else begin
          case (frame[31:30])
            FRAME_GOOD: begin
              dp = longint'(frame[29:16]);
              dt = longint'(frame[15:5]);
              if (!kind_q)
                p = round_div(DEC_PSI_GAIN * (DEC_PSI_SPAN - 2 * dp), DEC_PSI_DEN);
              else
                p = round_div(-(dp - DEC_INW_ZERO) * DEC_INW_GAIN, DEC_INW_DEN);
              t = round_div(DEC_TMP_GAIN * dt - DEC_TMP_OFFSET, DEC_TMP_DEN);
              press_q = 19'(p);
              temp_q = 13'(t);
              have_q = 1'b1;
              sample_ms = clock_ms;
              res.status = ST_OK;
            end
            FRAME_RESERVED: res.status = ST_RESERVED;
            FRAME_STALE:    res.status = ST_STALE;
            default:        res.status = ST_FAULT;
          endcase
        end
      end
      default: ;
    endcase
    res.pressure = press_q;
    res.temperature = temp_q;
    res.fresh = have_q && (32'(clock_ms - sample_ms) <= 32'(stale_q));
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    int      misses;
    if (rst) begin
      fail_count = 0;
      kind_q = 1'b0;
      wait_q = WAIT_RESET;
      stale_q = STALE_RESET;
      clock_ms = '0;
      start_ms = '0;
      sample_ms = '0;
      pending_q = 1'b0;
      have_q = 1'b0;
      press_q = '0;
      temp_q = '0;
      owed_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KIND:  kind_q = cfg_data[0];
          CFG_WAIT:  wait_q = cfg_data[7:0];
          CFG_STALE: stale_q = cfg_data[15:0];
          default: ;
        endcase
      end
      // Retire the oldest expectation before queueing this edge's input
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[37:0]);
        if (owed_q.size() == 0) begin
          $error("result beat with nothing expected, tdata %h", m_tdata);
          fail_count++;
        end else begin
          want = owed_q.pop_front();
          misses = 0;
          if (got.req !== want.req) begin
            $error("bus_request: expected %0d, got %0d", want.req, got.req);
            misses++;
          end
          if (got.status !== want.status) begin
            $error("event_status: expected %0d, got %0d", want.status, got.status);
            misses++;
          end
          if (got.pressure !== want.pressure) begin
            $error("pressure_sixteenth_pa: expected %0d, got %0d",
                   want.pressure, got.pressure);
            misses++;
          end
          if (got.temperature !== want.temperature) begin
            $error("temperature_sixteenth_c: expected %0d, got %0d",
                   want.temperature, got.temperature);
            misses++;
          end
          if (got.fresh !== want.fresh) begin
            $error("sample_fresh: expected %0d, got %0d", want.fresh, got.fresh);
            misses++;
          end
          if (m_tdata[39:38] !== 2'b00) begin
            $error("tdata padding: expected 0, got %0d", m_tdata[39:38]);
            misses++;
          end
          if (misses != 0)
            fail_count++;
        end
      end
      if (s_tvalid && s_tready) begin
        step_poller(s_tuser, s_tdata[0], s_tdata[32:1], want);
        owed_q.push_back(want);
      end
    end
    results_owed = owed_q.size();
  end

endmodule

// File: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aspd_pkg::*;

  // Opcode the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Length of the forced receiver stall, long enough to back the pipe up
  localparam int HOLD_CYCLES = 64;
  // Settle time after the last result
  localparam int SETTLE_CYCLES = 8;
  // Cycles without any beat before the run is declared hung
  localparam int QUIET_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [39:0]           s_tdata;
  logic [1:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [39:0]           m_tdata;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int   fail_count;
  int   results_owed;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   cur_wait;
  int   beats_sent;
  int   quiet_cycles = 0;
  int   hold_ask;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  airspeed_sensor_poll_and_decode_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Checker watches both streams and the register port, predicts every result
  // beat and scores the output against it
  aspd_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  // Sensor frame: status bits on top, then pressure count, temperature count and
  // five bits the decoder must ignore
  function automatic logic [31:0] frame_of(input logic [1:0] st, input logic [13:0] dp,
                                           input logic [10:0] dt, input logic [4:0] low);
    return {st, dp, dt, low};
  endfunction

  // Offer one event beat, after a random idle run, and hold it until taken.
  // Enter and leave on a falling edge; valid is only lowered by an idle run or
  // by the drain, so it never drops and rises in one step.
  task automatic send_beat(input logic [1:0] op, input logic ok, input logic [31:0] frame);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'b0, frame, ok};
    do begin
      @(posedge clk);
    end while (!s_tready);
    beats_sent++;
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted result has been taken
  task automatic await_all_results;
    s_tvalid <= 1'b0;
    while (results_owed != 0)
      @(negedge clk);
  endtask

  // Write all three registers back to back with the block idle
  task automatic configure(input logic kind_v, input logic [7:0] conv_ms,
                           input logic [15:0] stale_ms);
    await_all_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_KIND;
    cfg_data  <= CFG_DATA_W'(kind_v);
    @(negedge clk);
    cfg_index <= CFG_WAIT;
    cfg_data  <= CFG_DATA_W'(conv_ms);
    @(negedge clk);
    cfg_index <= CFG_STALE;
    cfg_data  <= stale_ms;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_wait = int'(conv_ms);
  endtask

  // Random traffic, mostly complete poll cycles the way a host would run them:
  // measure write, wait out the conversion on ticks, read the frame, idle a
  // little. The rest is noise: any opcode, any flag, any frame.
  task automatic run_polls(input int budget);
    int          start;
    int          ticks;
    logic        ok;
    logic [1:0]  st;
    logic [13:0] dp;
    logic [10:0] dt;
    start = beats_sent;
    while (beats_sent - start < budget) begin
      if ($urandom_range(99) < 80) begin
        ok = ($urandom_range(99) >= 5);
        send_beat(OP_WRITE, ok, $urandom);
        if (ok) begin
          // Mostly wait out the conversion; now and then read early
          if ($urandom_range(9) == 0)
            ticks = $urandom_range(cur_wait);
          else
            ticks = cur_wait + 1 + $urandom_range(2);
          repeat (ticks) send_beat(OP_TICK, 1'($urandom_range(1)), $urandom);
          // Lean on the ends of the counts and the inch-water zero point
          case ($urandom_range(5))
            0:       dp = '0;
            1:       dp = '1;
            2:       dp = 14'd1638;
            default: dp = 14'($urandom);
          endcase
          case ($urandom_range(4))
            0:       dt = '0;
            1:       dt = '1;
            default: dt = 11'($urandom);
          endcase
          if ($urandom_range(99) < 85) begin
            st = FRAME_GOOD;
          end else begin
            case ($urandom_range(2))
              0:       st = FRAME_RESERVED;
              1:       st = FRAME_STALE;
              default: st = FRAME_FAULT;
            endcase
          end
          send_beat(OP_READ, ($urandom_range(99) >= 5), frame_of(st, dp, dt, 5'($urandom)));
        end
        // Idle ticks let the sample age past short staleness limits
        repeat ($urandom_range(12)) send_beat(OP_TICK, 1'($urandom_range(1)), $urandom);
      end else begin
        send_beat(2'($urandom_range(3)), 1'($urandom_range(1)), $urandom);
      end
    end
  endtask

  // Receiver: random back-pressure, or a long hold-off each time one is asked
  // for, so that the pipe fills and s_tready has to drop
  initial begin : sink
    int hold_seen;
    hold_seen = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_ask) begin
        hold_seen = hold_ask;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Watchdog: any beat on either side resets the count
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tuser       = OP_TICK;
    s_tdata       = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_KIND;
    cfg_data      = '0;
    src_idle_pct  = 9;
    sink_idle_pct = 56;
    hold_ask      = 0;
    cur_wait      = int'(WAIT_RESET);
    beats_sent    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, reset configuration (psi formula, wait 10, limit 100).
    // Failed read before any sample: stored zeros, not fresh
    send_beat(OP_READ, 1'b0, frame_of(FRAME_GOOD, 14'h1234, 11'h155, 5'h0A));
    // Tick with nothing pending asks for a measure start
    send_beat(OP_TICK, 1'b0, '0);
    // Unused opcode changes nothing
    send_beat(OP_UNUSED, 1'b1, '1);
    // Failed measure write
    send_beat(OP_WRITE, 1'b0, '0);
    // Good write, then ticks: quiet through the wait, a read request once past it
    send_beat(OP_WRITE, 1'b1, '0);
    repeat (11) send_beat(OP_TICK, 1'b0, '0);
    // Bad frame status bits leave the stored sample alone
    send_beat(OP_READ, 1'b1, frame_of(FRAME_RESERVED, 14'h2000, 11'h400, 5'h00));
    send_beat(OP_READ, 1'b1, frame_of(FRAME_STALE, 14'h2000, 11'h400, 5'h00));
    send_beat(OP_READ, 1'b1, frame_of(FRAME_FAULT, 14'h2000, 11'h400, 5'h00));
    // Good frames at both ends of the counts and across the pressure zero
    send_beat(OP_READ, 1'b1, frame_of(FRAME_GOOD, 14'h0000, 11'h000, 5'h00));
    send_beat(OP_READ, 1'b1, frame_of(FRAME_GOOD, 14'h3FFF, 11'h7FF, 5'h1F));
    send_beat(OP_READ, 1'b1, frame_of(FRAME_GOOD, 14'd8191, 11'd1023, 5'h15));
    // Failed read of a good-looking frame keeps the old sample
    send_beat(OP_READ, 1'b0, frame_of(FRAME_GOOD, 14'd8192, 11'd1024, 5'h0A));

    // Sender mostly busy, receiver stalling more than half the time
    run_polls(300);
    configure(1'b1, 8'd0, 16'd0);
    run_polls(250);

    // Swap: sender idles often, receiver rarely
    src_idle_pct  = 56;
    sink_idle_pct = 9;
    configure(1'b0, 8'd255, 16'hFFFF);
    run_polls(560);
    configure(1'b1, 8'd3, 16'd7);
    hold_ask++;
    run_polls(250);

    // No idling on either side, with one more long receiver hold-off
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    configure(1'b0, 8'd1, 16'd20);
    hold_ask++;
    run_polls(300);

    await_all_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
